@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the icon tiler checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset only.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ hw/rtl/bitl_pkg.sv @@
// ---------------------------------------------------------------------------
// bitl_pkg
// Types, widths and pixel format helpers shared by the icon tiler modules.
// ---------------------------------------------------------------------------
package bitl_pkg;

    // Field widths
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 9;
    localparam int PIXEL_W     = 4 * CHAN_W;
    localparam int LINE_W      = 4 * SUM_W;
    localparam int COLUMN_W    = 10;
    localparam int ROW_W       = 9;
    localparam int BADGE_W     = 11;
    localparam int ADDR_W      = 12;
    localparam int BYTE_ADDR_W = 11;
    localparam int COLOR_W     = 16;
    localparam int NIBBLE_W    = 4;
    localparam int TILES_W     = 4;
    localparam int FIRST_W     = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TILES_ACROSS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_BADGE  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [TILES_W-1:0] TILES_RESET = 4'd1;
    localparam logic [FIRST_W-1:0] FIRST_RESET = 10'd0;

    // floor(a*15/255) == floor(a/17) == (a*241) >> 12 for every 8-bit a
    localparam logic [2*CHAN_W-1:0] ALPHA_RECIP = 16'd241;

    // Pixel held between the input register and the result stage
    typedef struct packed {
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [CHAN_W-1:0]   opacity;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [SUM_W-1:0]    sum_red;
        logic [SUM_W-1:0]    sum_green;
        logic [SUM_W-1:0]    sum_blue;
        logic [SUM_W-1:0]    sum_opacity;
        logic                line_ok;
    } stage_t;

    // One icon word apart from the badge index
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [COLOR_W-1:0]  color;
        logic [NIBBLE_W-1:0] nibble;
    } icon_word_t;

    function automatic logic [COLOR_W-1:0] pack_565(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [NIBBLE_W-1:0] alpha_to_nibble(input logic [CHAN_W-1:0] a);
        logic [2*CHAN_W-1:0] prod;
        prod = {{CHAN_W{1'b0}}, a} * ALPHA_RECIP;
        return prod[2*CHAN_W-1:2*CHAN_W-NIBBLE_W];
    endfunction

    // Morton code inside an 8x8 tile: x in bit 0, then y, alternating
    function automatic logic [5:0] morton_low(input logic [2:0] x, input logic [2:0] y);
        return {y[2], x[2], y[1], x[1], y[0], x[0]};
    endfunction

endpackage

@@ hw/rtl/bitl_ram.sv @@
// ---------------------------------------------------------------------------
// bitl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module bitl_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/bitl_front.sv @@
// ---------------------------------------------------------------------------
// bitl_front
// Input register, left-pixel hold, pair sums and the line buffer of
// top-row pair sums.
// ---------------------------------------------------------------------------
module bitl_front #(
    parameter int MAX_TILES_ACROSS = 12,
    parameter int TILE_EDGE        = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bitl_pkg::CHAN_W-1:0]   red,
    input  logic [bitl_pkg::CHAN_W-1:0]   green,
    input  logic [bitl_pkg::CHAN_W-1:0]   blue,
    input  logic [bitl_pkg::CHAN_W-1:0]   opacity,
    input  logic [bitl_pkg::COLUMN_W-1:0] column,
    input  logic [bitl_pkg::ROW_W-1:0]    row,
    input  logic                          stage_free,
    output logic                          stage_valid,
    output bitl_pkg::stage_t              stage,
    output logic [bitl_pkg::LINE_W-1:0]   line_word
);
    import bitl_pkg::*;

    localparam int LINE_DEPTH = (MAX_TILES_ACROSS * TILE_EDGE) / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int LI_W       = COLUMN_W - 1;

    logic                stage_valid_reg;
    logic                stage_valid_next;
    stage_t              stage_reg;
    stage_t              stage_next;
    logic [PIXEL_W-1:0]  hold_reg;
    logic [PIXEL_W-1:0]  hold_next;
    logic                in_take;
    logic [LI_W-1:0]     line_idx;
    logic                line_ok;
    logic [SUM_W-1:0]    sum_red;
    logic [SUM_W-1:0]    sum_green;
    logic [SUM_W-1:0]    sum_blue;
    logic [SUM_W-1:0]    sum_opacity;
    logic                line_wr_en;
    logic                line_rd_en;

    // Handshake: the stage takes a word when empty or when it moves on
    assign in_stall = stage_valid_reg & ~stage_free;
    assign in_take  = in_valid & ~in_stall;

    // Horizontal pair sums with the previous pixel
    always_comb
    begin
        sum_red     = SUM_W'(red)     + SUM_W'(hold_reg[CHAN_W-1:0]);
        sum_green   = SUM_W'(green)   + SUM_W'(hold_reg[2*CHAN_W-1:CHAN_W]);
        sum_blue    = SUM_W'(blue)    + SUM_W'(hold_reg[3*CHAN_W-1:2*CHAN_W]);
        sum_opacity = SUM_W'(opacity) + SUM_W'(hold_reg[4*CHAN_W-1:3*CHAN_W]);
    end

    // Line buffer access on odd columns: even rows store, odd rows fetch
    assign line_idx   = column[COLUMN_W-1:1];
    assign line_ok    = (LI_W + 1)'(line_idx) < (LI_W + 1)'(LINE_DEPTH);
    assign line_wr_en = in_take & column[0] & ~row[0] & line_ok;
    assign line_rd_en = in_take & column[0] & row[0];

    bitl_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_idx[LINE_AW-1:0]),
        .wr_data ({sum_opacity, sum_blue, sum_green, sum_red}),
        .rd_en   (line_rd_en),
        .rd_addr (line_idx[LINE_AW-1:0]),
        .rd_data (line_word)
    );

    // Next values of the stage and the hold register
    always_comb
    begin
        stage_valid_next = in_take | (stage_valid_reg & ~stage_free);
        hold_next        = in_take ? {opacity, blue, green, red} : hold_reg;
        stage_next       = stage_reg;
        if (in_take)
        begin
            stage_next.red         = red;
            stage_next.green       = green;
            stage_next.blue        = blue;
            stage_next.opacity     = opacity;
            stage_next.column      = column;
            stage_next.row         = row;
            stage_next.sum_red     = sum_red;
            stage_next.sum_green   = sum_green;
            stage_next.sum_blue    = sum_blue;
            stage_next.sum_opacity = sum_opacity;
            stage_next.line_ok     = line_ok;
        end
    end

    // Control and hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            hold_reg        <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            hold_reg        <= hold_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

@@ hw/rtl/bitl_encode.sv @@
// ---------------------------------------------------------------------------
// bitl_encode
// Builds the full-size and half-size icon words of one pixel and presents
// them in order from the output register.
// ---------------------------------------------------------------------------
module bitl_encode #(
    parameter int TILE_EDGE = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             stage_valid,
    input  bitl_pkg::stage_t                 stage,
    input  logic [bitl_pkg::LINE_W-1:0]      line_word,
    output logic                             stage_free,
    input  logic [bitl_pkg::TILES_W-1:0]     tiles_across,
    input  logic [bitl_pkg::FIRST_W-1:0]     first_badge_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             icon_size,
    output logic [bitl_pkg::BADGE_W-1:0]     badge_index,
    output logic [bitl_pkg::ADDR_W-1:0]      pixel_address,
    output logic [bitl_pkg::COLOR_W-1:0]     color_565,
    output logic [bitl_pkg::NIBBLE_W-1:0]    alpha_nibble,
    output logic [bitl_pkg::BYTE_ADDR_W-1:0] alpha_byte_address,
    output logic                             alpha_high_half,
    output logic                             last_result
);
    import bitl_pkg::*;

    localparam int EB     = $clog2(TILE_EDGE);
    localparam int RB_W   = ROW_W - EB;
    localparam int CB_W   = COLUMN_W - EB;
    localparam int PROD_W = RB_W + TILES_W;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                phase_reg;
    logic                phase_next;
    logic                has_half_reg;
    logic                has_half_next;
    logic [BADGE_W-1:0]  badge_reg;
    icon_word_t          full_reg;
    icon_word_t          half_reg;
    logic                out_take;
    logic                out_last;
    logic                stage_half;
    logic [RB_W-1:0]     badge_row;
    logic [CB_W-1:0]     badge_col;
    logic [PROD_W-1:0]   badge_prod;
    logic [BADGE_W-1:0]  badge_calc;
    logic [ADDR_W-1:0]   fx;
    logic [ADDR_W-1:0]   fy;
    logic [ADDR_W-1:0]   hx;
    logic [ADDR_W-1:0]   hy;
    logic [ADDR_W-1:0]   full_tile;
    logic [ADDR_W-1:0]   half_tile;
    logic [LINE_W-1:0]   top_sums;
    logic [SUM_W:0]      tot_red;
    logic [SUM_W:0]      tot_green;
    logic [SUM_W:0]      tot_blue;
    logic [SUM_W:0]      tot_opacity;
    icon_word_t          full_calc;
    icon_word_t          half_calc;
    icon_word_t          shown;

    // Output handshake; the stage moves on once the last word is taken
    assign out_take   = out_valid_reg & ~out_stall;
    assign out_last   = phase_reg | ~has_half_reg;
    assign stage_free = ~out_valid_reg | (out_take & out_last);
    assign stage_half = stage.column[0] & stage.row[0];

    // Badge index: first + badge row * badges across + badge column
    always_comb
    begin
        badge_row  = stage.row[ROW_W-1:EB];
        badge_col  = stage.column[COLUMN_W-1:EB];
        badge_prod = PROD_W'(badge_row) * PROD_W'(tiles_across);
        badge_calc = BADGE_W'(first_badge_index) + BADGE_W'(badge_prod)
                   + BADGE_W'(badge_col);
    end

    // Tile numbers for the full-size and half-size icons
    always_comb
    begin
        fx        = ADDR_W'(stage.column[EB-1:0]);
        fy        = ADDR_W'(stage.row[EB-1:0]);
        hx        = fx >> 1;
        hy        = fy >> 1;
        full_tile = ((fy >> 3) << (EB - 3)) | (fx >> 3);
        half_tile = ((hy >> 3) << (EB - 4)) | (hx >> 3);
    end

    // 2x2 channel totals: bottom pair sums plus stored top pair sums
    always_comb
    begin
        top_sums    = stage.line_ok ? line_word : '0;
        tot_red     = (SUM_W + 1)'(stage.sum_red)     + (SUM_W + 1)'(top_sums[SUM_W-1:0]);
        tot_green   = (SUM_W + 1)'(stage.sum_green)
                    + (SUM_W + 1)'(top_sums[2*SUM_W-1:SUM_W]);
        tot_blue    = (SUM_W + 1)'(stage.sum_blue)
                    + (SUM_W + 1)'(top_sums[3*SUM_W-1:2*SUM_W]);
        tot_opacity = (SUM_W + 1)'(stage.sum_opacity)
                    + (SUM_W + 1)'(top_sums[4*SUM_W-1:3*SUM_W]);
    end

    // Icon words: full pixel as is, half pixel as the 2x2 floor average
    always_comb
    begin
        full_calc.addr   = (full_tile << 6) | ADDR_W'(morton_low(fx[2:0], fy[2:0]));
        full_calc.color  = pack_565(stage.red, stage.green, stage.blue);
        full_calc.nibble = alpha_to_nibble(stage.opacity);
        half_calc.addr   = (half_tile << 6) | ADDR_W'(morton_low(hx[2:0], hy[2:0]));
        half_calc.color  = pack_565(tot_red[SUM_W:2], tot_green[SUM_W:2], tot_blue[SUM_W:2]);
        half_calc.nibble = alpha_to_nibble(tot_opacity[SUM_W:2]);
    end

    // Output sequencing: full word first, then the half word if any
    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        has_half_next  = has_half_reg;
        if (stage_free)
        begin
            out_valid_next = stage_valid;
            phase_next     = 1'b0;
            has_half_next  = stage_half;
        end
        else if (out_take)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            has_half_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            has_half_reg  <= has_half_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (stage_free)
        begin
            badge_reg <= badge_calc;
            full_reg  <= full_calc;
            half_reg  <= half_calc;
        end
    end

    // Port view of the word on show
    assign shown              = phase_reg ? half_reg : full_reg;
    assign out_valid          = out_valid_reg;
    assign icon_size          = phase_reg;
    assign badge_index        = badge_reg;
    assign pixel_address      = shown.addr;
    assign color_565          = shown.color;
    assign alpha_nibble       = shown.nibble;
    assign alpha_byte_address = shown.addr[ADDR_W-1:1];
    assign alpha_high_half    = shown.addr[0];
    assign last_result        = out_last;

endmodule

@@ hw/rtl/badge_icon_tiler.sv @@
// ---------------------------------------------------------------------------
// badge_icon_tiler
// Cuts a raster-order RGBA8888 sheet into square badges and emits swizzled
// RGB565 / 4-bit alpha icon words at full and half size.
// ---------------------------------------------------------------------------
// The block takes one pixel word per cycle unless it stalls the input. Each
// pixel gives one full-size icon word; a pixel on an odd row and an odd column
// gives a second, half-size word once the full-size one is taken, holding the
// output register for both words. Throughput is set by the single output
// register: one result word per cycle while out_stall is low. The line buffer
// of top-row pair sums is a RAM of MAX_TILES_ACROSS*TILE_EDGE/2 entries
// written and read at pixel accept; it needs no clearing pass, and a half-size
// word whose top row was never stored carries undefined color. The user must
// write configuration only while idle; the block does not enforce it.
module badge_icon_tiler #(
    parameter int MAX_TILES_ACROSS = 12,
    parameter int TILE_EDGE        = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bitl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bitl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bitl_pkg::CHAN_W-1:0]         red,
    input  logic [bitl_pkg::CHAN_W-1:0]         green,
    input  logic [bitl_pkg::CHAN_W-1:0]         blue,
    input  logic [bitl_pkg::CHAN_W-1:0]         opacity,
    input  logic [bitl_pkg::COLUMN_W-1:0]       column,
    input  logic [bitl_pkg::ROW_W-1:0]          row,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                icon_size,
    output logic [bitl_pkg::BADGE_W-1:0]        badge_index,
    output logic [bitl_pkg::ADDR_W-1:0]         pixel_address,
    output logic [bitl_pkg::COLOR_W-1:0]        color_565,
    output logic [bitl_pkg::NIBBLE_W-1:0]       alpha_nibble,
    output logic [bitl_pkg::BYTE_ADDR_W-1:0]    alpha_byte_address,
    output logic                                alpha_high_half,
    output logic                                last_result
);
    import bitl_pkg::*;

    logic [TILES_W-1:0] tiles_reg;
    logic [TILES_W-1:0] tiles_next;
    logic [FIRST_W-1:0] first_reg;
    logic [FIRST_W-1:0] first_next;
    logic               stage_valid;
    logic               stage_free;
    stage_t             stage;
    logic [LINE_W-1:0]  line_word;

    // Configuration register writes
    always_comb
    begin
        tiles_next = tiles_reg;
        first_next = first_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TILES_ACROSS: tiles_next = cfg_data[TILES_W-1:0];
                REG_FIRST_BADGE:  first_next = cfg_data[FIRST_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_reg <= TILES_RESET;
            first_reg <= FIRST_RESET;
        end
        else
        begin
            tiles_reg <= tiles_next;
            first_reg <= first_next;
        end
    end

    // Input register, pair sums and line buffer
    bitl_front #(
        .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
        .TILE_EDGE        (TILE_EDGE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .opacity     (opacity),
        .column      (column),
        .row         (row),
        .stage_free  (stage_free),
        .stage_valid (stage_valid),
        .stage       (stage),
        .line_word   (line_word)
    );

    // Result words and output register
    bitl_encode #(
        .TILE_EDGE (TILE_EDGE)
    ) u_encode (
        .clk                (clk),
        .rst_n              (rst_n),
        .stage_valid        (stage_valid),
        .stage              (stage),
        .line_word          (line_word),
        .stage_free         (stage_free),
        .tiles_across       (tiles_reg),
        .first_badge_index  (first_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .icon_size          (icon_size),
        .badge_index        (badge_index),
        .pixel_address      (pixel_address),
        .color_565          (color_565),
        .alpha_nibble       (alpha_nibble),
        .alpha_byte_address (alpha_byte_address),
        .alpha_high_half    (alpha_high_half),
        .last_result        (last_result)
    );

endmodule

@@ hw/rtl/bitl_checker.sv @@
// ---------------------------------------------------------------------------
// bitl_checker
// Port-level checks of the icon tiler output sequence, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bitl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                icon_size,
    input logic [bitl_pkg::BADGE_W-1:0]        badge_index,
    input logic [bitl_pkg::ADDR_W-1:0]         pixel_address,
    input logic [bitl_pkg::BYTE_ADDR_W-1:0]    alpha_byte_address,
    input logic                                alpha_high_half,
    input logic                                last_result
);

    // A stalled word holds
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(icon_size) && $stable(pixel_address) && $stable(badge_index))

    // The half-size word always closes its pixel
    `ASSERT_IMPLY(a_half_is_last, clk, rst_n, out_valid && icon_size, last_result)

    // A taken word that is not last is followed at once by its half-size word
    `ASSERT_NEXT(a_half_follows, clk, rst_n, out_valid && !out_stall && !last_result, out_valid && icon_size && $stable(badge_index))

    // Alpha plane position matches the pixel address
    `ASSERT_IMPLY(a_alpha_pos, clk, rst_n, out_valid, (alpha_byte_address == pixel_address[11:1]) && (alpha_high_half == pixel_address[0]))

endmodule

bind badge_icon_tiler bitl_checker u_bitl_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .icon_size          (icon_size),
    .badge_index        (badge_index),
    .pixel_address      (pixel_address),
    .alpha_byte_address (alpha_byte_address),
    .alpha_high_half    (alpha_high_half),
    .last_result        (last_result)
);

@@ tb/sv/icon_word_checker.sv @@
// ---------------------------------------------------------------------------
// icon_word_checker
// Watches the pixel, icon and register ports of the badge icon tiler, keeps
// its own copy of the line of top-row pair sums and of the previous pixel,
// predicts the icon words each taken pixel causes and compares every icon
// word that leaves the block, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module icon_word_checker #(
    parameter int MAX_TILES_ACROSS = 12,
    parameter int TILE_EDGE        = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bitl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bitl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [bitl_pkg::CHAN_W-1:0]      red,
    input  logic [bitl_pkg::CHAN_W-1:0]      green,
    input  logic [bitl_pkg::CHAN_W-1:0]      blue,
    input  logic [bitl_pkg::CHAN_W-1:0]      opacity,
    input  logic [bitl_pkg::COLUMN_W-1:0]    column,
    input  logic [bitl_pkg::ROW_W-1:0]       row,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             icon_size,
    input  logic [bitl_pkg::BADGE_W-1:0]     badge_index,
    input  logic [bitl_pkg::ADDR_W-1:0]      pixel_address,
    input  logic [bitl_pkg::COLOR_W-1:0]     color_565,
    input  logic [bitl_pkg::NIBBLE_W-1:0]    alpha_nibble,
    input  logic [bitl_pkg::BYTE_ADDR_W-1:0] alpha_byte_address,
    input  logic                             alpha_high_half,
    input  logic                             last_result,
    output int                               mismatch_count,
    output int                               words_pending
);
    import bitl_pkg::*;

    localparam int LINE_DEPTH = (MAX_TILES_ACROSS * TILE_EDGE) / 2;

    typedef struct packed {
        logic                   size;
        logic [BADGE_W-1:0]     badge;
        logic [ADDR_W-1:0]      addr;
        logic [COLOR_W-1:0]     color;
        logic [NIBBLE_W-1:0]    nibble;
        logic [BYTE_ADDR_W-1:0] byte_addr;
        logic                   high_half;
        logic                   last;
    } expected_word_t;

    expected_word_t     expected_words[$];
    logic [LINE_W-1:0]  pair_sums [0:LINE_DEPTH-1];
    logic [PIXEL_W-1:0] left_pixel;
    logic [TILES_W-1:0] tiles_cfg;
    logic [FIRST_W-1:0] first_cfg;
    int                 word_no;

    // Address inside an icon of the given edge: 8x8 tiles in raster order,
    // Morton order inside a tile with x in the lowest bit
    function automatic logic [ADDR_W-1:0] tiled_address(
        input int unsigned x,
        input int unsigned y,
        input int unsigned edge_len
    );
        int unsigned tile_num;
        logic [31:0] interleaved;
        logic [31:0] full;
        tile_num    = (y >> 3) * (edge_len >> 3) + (x >> 3);
        interleaved = '0;
        for (int k = 0; k < 3; k++)
        begin
            interleaved[2*k]   = x[k];
            interleaved[2*k+1] = y[k];
        end
        full = (tile_num << 6) + interleaved;
        return full[ADDR_W-1:0];
    endfunction

    function automatic expected_word_t make_word(
        input logic               size,
        input logic [BADGE_W-1:0] badge,
        input logic [ADDR_W-1:0]  addr,
        input int unsigned        r,
        input int unsigned        g,
        input int unsigned        b,
        input int unsigned        a,
        input logic               last
    );
        expected_word_t w;
        int unsigned c;
        c           = ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
        w.size      = size;
        w.badge     = badge;
        w.addr      = addr;
        w.color     = c[COLOR_W-1:0];
        w.nibble    = NIBBLE_W'((a * 15) / 255);
        w.byte_addr = addr[ADDR_W-1:1];
        w.high_half = addr[0];
        w.last      = last;
        return w;
    endfunction

    // Work out the icon words for one taken pixel and update the state
    task automatic predict_pixel();
        int unsigned  r, g, b, a, col, rw, x, y, badge_sum, line_idx;
        int unsigned  sum_r, sum_g, sum_b, sum_a;
        logic [LINE_W-1:0] entry;
        logic         half;
        r         = red;
        g         = green;
        b         = blue;
        a         = opacity;
        col       = column;
        rw        = row;
        x         = col % TILE_EDGE;
        y         = rw % TILE_EDGE;
        badge_sum = first_cfg + (rw / TILE_EDGE) * tiles_cfg + col / TILE_EDGE;
        half      = column[0] && row[0];
        line_idx  = col >> 1;

        expected_words.insert(expected_words.size(), make_word(1'b0,
            badge_sum[BADGE_W-1:0], tiled_address(x, y, TILE_EDGE), r, g, b, a, !half));

        if (column[0])
        begin
            // pair sum with whatever pixel came just before
            sum_r = r + left_pixel[7:0];
            sum_g = g + left_pixel[15:8];
            sum_b = b + left_pixel[23:16];
            sum_a = a + left_pixel[31:24];
            if (!row[0])
            begin
                if (line_idx < LINE_DEPTH)
                    pair_sums[line_idx] = {sum_a[8:0], sum_b[8:0], sum_g[8:0], sum_r[8:0]};
            end
            else
            begin
                // beyond the line the top row reads as zero
                entry = (line_idx < LINE_DEPTH) ? pair_sums[line_idx] : '0;
                expected_words.insert(expected_words.size(), make_word(1'b1,
                    badge_sum[BADGE_W-1:0], tiled_address(x >> 1, y >> 1, TILE_EDGE / 2),
                    (sum_r + entry[8:0]) >> 2, (sum_g + entry[17:9]) >> 2,
                    (sum_b + entry[26:18]) >> 2, (sum_a + entry[35:27]) >> 2, 1'b1));
            end
        end

        left_pixel = {opacity, blue, green, red};
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: icon word %0d: %s", $time, word_no, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task automatic check_word();
        expected_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("word arrived with nothing expected");
        end
        else
        begin
            want = expected_words.pop_front();
            compare_field("icon_size", 16'(icon_size), 16'(want.size));
            compare_field("badge_index", 16'(badge_index), 16'(want.badge));
            compare_field("pixel_address", 16'(pixel_address), 16'(want.addr));
            compare_field("color_565", color_565, want.color);
            compare_field("alpha_nibble", 16'(alpha_nibble), 16'(want.nibble));
            compare_field("alpha_byte_address", 16'(alpha_byte_address),
                          16'(want.byte_addr));
            compare_field("alpha_high_half", 16'(alpha_high_half), 16'(want.high_half));
            compare_field("last_result", 16'(last_result), 16'(want.last));
        end
        word_no++;
    endtask

    // Outputs are checked before the new pixel is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_cfg  = TILES_RESET;
            first_cfg  = FIRST_RESET;
            left_pixel = '0;
            for (int i = 0; i < LINE_DEPTH; i++)
                pair_sums[i] = '0;
            expected_words.delete();
            words_pending  = 0;
            mismatch_count = 0;
            word_no        = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_word();
            if (in_valid && !in_stall)
                predict_pixel();
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TILES_ACROSS: tiles_cfg = cfg_data[TILES_W-1:0];
                    REG_FIRST_BADGE:  first_cfg = cfg_data[FIRST_W-1:0];
                    default:          ;
                endcase
            end
            words_pending = expected_words.size();
        end
    end

endmodule

@@ tb/sv/tb_badge_icon_tiler.sv @@
// ---------------------------------------------------------------------------
// tb_badge_icon_tiler
// Drives pixel words into the badge icon tiler: a directed set of corner
// pixels, then raster blocks of random pixels mixed with stray pixels, over
// several register settings and with random gaps and stalls on both sides.
// The icon word checker predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_badge_icon_tiler;
    import bitl_pkg::*;

    localparam int MAX_TILES_ACROSS = 12;
    localparam int TILE_EDGE        = 64;
    localparam int LINE_DEPTH       = (MAX_TILES_ACROSS * TILE_EDGE) / 2;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 166;
    localparam int IDLE_LIMIT       = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [CHAN_W-1:0]      red, green, blue, opacity;
    logic [COLUMN_W-1:0]    column;
    logic [ROW_W-1:0]       row;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   icon_size;
    logic [BADGE_W-1:0]     badge_index;
    logic [ADDR_W-1:0]      pixel_address;
    logic [COLOR_W-1:0]     color_565;
    logic [NIBBLE_W-1:0]    alpha_nibble;
    logic [BYTE_ADDR_W-1:0] alpha_byte_address;
    logic                   alpha_high_half;
    logic                   last_result;
    int                     mismatch_count;
    int                     words_pending;

    // Stimulus bookkeeping
    bit                     line_written [0:LINE_DEPTH-1];
    int                     pixels_sent;
    int                     send_idle_pct;
    int                     stall_pct;
    int                     idle_cycles;

    always #5 clk = ~clk;

    badge_icon_tiler #(
        .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
        .TILE_EDGE        (TILE_EDGE)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .opacity            (opacity),
        .column             (column),
        .row                (row),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .icon_size          (icon_size),
        .badge_index        (badge_index),
        .pixel_address      (pixel_address),
        .color_565          (color_565),
        .alpha_nibble       (alpha_nibble),
        .alpha_byte_address (alpha_byte_address),
        .alpha_high_half    (alpha_high_half),
        .last_result        (last_result)
    );

    icon_word_checker #(
        .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
        .TILE_EDGE        (TILE_EDGE)
    ) u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .opacity            (opacity),
        .column             (column),
        .row                (row),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .icon_size          (icon_size),
        .badge_index        (badge_index),
        .pixel_address      (pixel_address),
        .color_565          (color_565),
        .alpha_nibble       (alpha_nibble),
        .alpha_byte_address (alpha_byte_address),
        .alpha_high_half    (alpha_high_half),
        .last_result        (last_result),
        .mismatch_count     (mismatch_count),
        .words_pending      (words_pending)
    );

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: cycles with no word taken on either side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [CHAN_W-1:0] rand_chan();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return CHAN_W'($urandom);
    endfunction

    // One pixel word; a half-size pixel whose top row was never stored is
    // moved up to the even row so that it stores the entry instead
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a,
                              input logic [COLUMN_W-1:0] col, input logic [ROW_W-1:0] rw);
        int line_idx;
        line_idx = col >> 1;
        if (col[0] && rw[0] && line_idx < LINE_DEPTH && !line_written[line_idx])
            rw[0] = 1'b0;
        if (col[0] && !rw[0] && line_idx < LINE_DEPTH)
            line_written[line_idx] = 1'b1;

        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        red      <= r;
        green    <= g;
        blue     <= b;
        opacity  <= a;
        column   <= col;
        row      <= rw;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    task automatic send_random_pixel(input int col, input int rw);
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                   COLUMN_W'(col), ROW_W'(rw));
    endtask

    // Raster block of random pixels, mostly inside the sheet
    task automatic send_block(input int w, input int h);
        int col0, row0;
        if ($urandom_range(7) == 0)
            col0 = $urandom_range(1024 - w);
        else
            col0 = $urandom_range(768 - w);
        if ($urandom_range(7) == 0)
            row0 = $urandom_range(512 - h);
        else
            row0 = $urandom_range(384 - h);
        if ($urandom_range(3) != 0)
            row0 = row0 & ~1;
        for (int y = row0; y < row0 + h; y++)
            for (int x = col0; x < col0 + w; x++)
                send_random_pixel(x, y);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stop sending and wait for every predicted word to come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
    endtask

    task automatic send_directed();
        // odd column as first pixel: left pixel is the reset zero
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd1, 9'd0);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 10'd0, 9'd1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd1, 9'd1);
        // far corner, beyond the line: top row reads zero
        send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 10'd1023, 9'd511);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 10'd1022, 9'd510);
        send_pixel(8'hFF, 8'hFF, 8'h00, 8'h00, 10'd1023, 9'd510);
        send_pixel(8'h00, 8'h00, 8'hFF, 8'hFF, 10'd1023, 9'd511);
        // alpha steps around the nibble boundaries
        send_pixel(8'h07, 8'h03, 8'h08, 8'h10, 10'd2, 9'd0);
        send_pixel(8'h08, 8'h04, 8'h07, 8'h11, 10'd3, 9'd0);
        send_pixel(8'hF8, 8'hFC, 8'hF7, 8'hFE, 10'd2, 9'd1);
        send_pixel(8'h80, 8'h7F, 8'h81, 8'h80, 10'd3, 9'd1);
        // last entry of the line, at the sheet edge
        send_pixel(8'h01, 8'h02, 8'h03, 8'h01, 10'd766, 9'd382);
        send_pixel(8'hFE, 8'hFD, 8'hFC, 8'hFF, 10'd767, 9'd382);
        send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 10'd766, 9'd383);
        send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 10'd767, 9'd383);
        // first entry past the line
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 10'd768, 9'd384);
        send_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0, 10'd769, 9'd385);
        // badge boundaries
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 10'd64, 9'd64);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 10'd63, 9'd62);
        send_pixel(8'h00, 8'h00, 8'hFF, 8'h00, 10'd63, 9'd63);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 10'd0, 9'd0);
        send_pixel(8'h3C, 8'hC3, 8'h5A, 8'hA5, 10'd512, 9'd256);
    endtask

    initial
    begin
        int phase_end;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_TILES_ACROSS;
        cfg_data      = '0;
        in_valid      = 1'b0;
        red           = '0;
        green         = '0;
        blue          = '0;
        opacity       = '0;
        column        = '0;
        row           = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        pixels_sent   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // idling pattern of this phase
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 75;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 75;
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                end
            endcase

            // register settings, written while the block is drained
            case (phase)
                0: ;
                1:
                begin
                    write_reg(REG_TILES_ACROSS, 10'd12);
                    write_reg(REG_FIRST_BADGE, 10'd999);
                end
                2:
                begin
                    write_reg(REG_FIRST_BADGE, 10'd0);
                    write_reg(REG_TILES_ACROSS, 10'd0);
                end
                3:
                begin
                    write_reg(REG_TILES_ACROSS, {6'h3F, 4'd15});
                    write_reg(REG_FIRST_BADGE, 10'd1023);
                end
                4:
                begin
                    write_reg(REG_TILES_ACROSS, 10'd1);
                    write_reg(REG_FIRST_BADGE, 10'd512);
                end
                5:
                begin
                    write_reg(REG_TILES_ACROSS, CFG_DATA_W'($urandom_range(1, 12)));
                    write_reg(REG_FIRST_BADGE, CFG_DATA_W'($urandom_range(999)));
                end
                6:
                begin
                    write_reg(REG_TILES_ACROSS, {6'h2A, 4'd7});
                    write_reg(REG_FIRST_BADGE, 10'd1);
                end
                default:
                begin
                    write_reg(REG_TILES_ACROSS, CFG_DATA_W'($urandom));
                    write_reg(REG_FIRST_BADGE, CFG_DATA_W'($urandom));
                end
            endcase

            if (phase == 0)
                send_directed();

            // mostly raster blocks, some stray pixels anywhere
            phase_end = (phase + 1) * ITEMS_PER_PHASE;
            while (pixels_sent < phase_end)
            begin
                if ($urandom_range(4) != 0)
                    send_block($urandom_range(2, 24), $urandom_range(2, 6));
                else
                    repeat ($urandom_range(1, 6))
                        send_random_pixel($urandom_range(1023), $urandom_range(511));
            end
            drain();
        end

        // catch any word the block sends beyond the predicted ones
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
